// ===== design/key_to_midi_note_mapper_macros.svh =====
// assertion macros shared by the mapper's checking code
`ifndef KEY_TO_MIDI_NOTE_MAPPER_MACROS_SVH
`define KEY_TO_MIDI_NOTE_MAPPER_MACROS_SVH

// same-cycle implication, checked on i_clk outside reset
`define KMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define KMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/kmm_pkg.sv =====
// shared constants, codes and types of the key to midi note mapper
package kmm_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_WIDTH   = 16;
    localparam int ENTRY_W     = 5;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_AW      = TBL_AW + 1;
    localparam int RAM_DEPTH   = 2 ** RAM_AW;
    localparam int NOTE_W      = 7;
    localparam int CHAN_W      = 4;
    localparam int VEL_W       = 7;
    localparam int HELD_W      = NOTE_W + CHAN_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    localparam logic [1:0] CMD_PRESS    = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_WR_LOWER = 2'd2;
    localparam logic [1:0] CMD_WR_UPPER = 2'd3;

    localparam logic EV_OFF = 1'b0;
    localparam logic EV_ON  = 1'b1;

    localparam logic TBL_LOWER = 1'b0;
    localparam logic TBL_UPPER = 1'b1;

    localparam logic [VEL_W-1:0] NOTE_OFF_VEL = 7'd127;
    localparam logic signed [9:0] SEMITONES   = 10'sd12;
    localparam logic signed [5:0] OCT_BIAS    = 6'sd2;
    localparam logic signed [9:0] NOTE_MAX    = 10'sd127;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_OCT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_OCT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_VEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_VEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CHAN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CHAN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CNT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CNT  = 3'd7;

    typedef struct packed {
        logic [4:0]        lo_oct;
        logic [4:0]        hi_oct;
        logic [VEL_W-1:0]  lo_vel;
        logic [VEL_W-1:0]  hi_vel;
        logic [CHAN_W-1:0] lo_chan;
        logic [CHAN_W-1:0] hi_chan;
        logic [5:0]        lower_count;
        logic [5:0]        upper_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           cmd;
        logic                 is_write;
        logic [KEY_WIDTH-1:0] key;
        logic [ENTRY_W-1:0]   idx;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef struct packed {
        logic emitting;
        logic searching;
    } t_back_stat;

endpackage

// ===== design/kmm_in_if.sv =====
// input channel: key commands
interface kmm_in_if;
    import kmm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [KEY_WIDTH-1:0] key_code;
    logic [ENTRY_W-1:0]   entry_index;

    modport source (output valid, output command, output key_code, output entry_index,
                    input ready);
    modport sink   (input valid, input command, input key_code, input entry_index,
                    output ready);
endinterface

// ===== design/kmm_out_if.sv =====
// output channel: midi note events
interface kmm_out_if;
    import kmm_pkg::*;
    logic              valid;
    logic              ready;
    logic              event_kind;
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              last;

    modport source (output valid, output event_kind, output channel, output note,
                    output velocity, output last, input ready);
    modport sink   (input valid, input event_kind, input channel, input note,
                    input velocity, input last, output ready);
endinterface

// ===== design/kmm_ram.sv =====
// generic simple dual-port ram with registered read
module kmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/kmm_front.sv =====
// front end: accepts key commands, classifies them and queues them for the sequencer
module kmm_front import kmm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmm_in_if.sink     i_in,
    input  logic       i_pop,
    output t_queue_out o_q
);
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      w_item;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;

    always_comb begin
        w_item.cmd      = i_in.command;
        w_item.is_write = (i_in.command == CMD_WR_LOWER) || (i_in.command == CMD_WR_UPPER);
        w_item.key      = i_in.key_code;
        w_item.idx      = i_in.entry_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= w_item;
        end
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_q[r_rp];
endmodule

// ===== design/kmm_back.sv =====
// back end: table writes, table search, note decision and event output
module kmm_back import kmm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_out i_q,
    output logic       o_pop,
    input  t_cfg       i_cfg,
    kmm_out_if.source  o_out,
    output t_back_stat o_stat
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]             r_state,    n_state;
    logic                   r_rel,      n_rel;
    logic [KEY_WIDTH-1:0]   r_key,      n_key;
    logic                   r_tbl,      n_tbl;
    logic [CNT_W-1:0]       r_ptr,      n_ptr;
    logic                   r_cmp_vld,  n_cmp_vld;
    logic                   r_cmp_tbl,  n_cmp_tbl;
    logic [TBL_AW-1:0]      r_cmp_idx,  n_cmp_idx;
    logic [TABLE_DEPTH-1:0] r_act_lo,   n_act_lo;
    logic [TABLE_DEPTH-1:0] r_act_hi,   n_act_hi;
    logic                   r_off_pend, n_off_pend;
    logic                   r_on_pend,  n_on_pend;
    logic [NOTE_W-1:0]      r_off_note, n_off_note;
    logic [CHAN_W-1:0]      r_off_chan, n_off_chan;
    logic [NOTE_W-1:0]      r_on_note,  n_on_note;
    logic [CHAN_W-1:0]      r_on_chan,  n_on_chan;
    logic [VEL_W-1:0]       r_on_vel,   n_on_vel;
    logic                   r_out_vld,  n_out_vld;
    logic                   r_out_kind, n_out_kind;
    logic [CHAN_W-1:0]      r_out_chan, n_out_chan;
    logic [NOTE_W-1:0]      r_out_note, n_out_note;
    logic [VEL_W-1:0]       r_out_vel,  n_out_vel;
    logic                   r_out_last, n_out_last;

    logic                   code_we;
    logic [RAM_AW-1:0]      code_waddr;
    logic [RAM_AW-1:0]      code_raddr;
    logic [KEY_WIDTH-1:0]   code_rd;
    logic                   held_we;
    logic [HELD_W-1:0]      held_wdata;
    logic [HELD_W-1:0]      held_rd;
    logic [NOTE_W-1:0]      held_note;
    logic [CHAN_W-1:0]      held_chan;

    logic [CNT_W-1:0]       lim_lo;
    logic [CNT_W-1:0]       lim_hi;
    logic [CNT_W-1:0]       lim;
    logic                   hit;
    logic                   act;
    logic [4:0]             oct;
    logic signed [5:0]      oct_p2;
    logic signed [9:0]      note_s;
    logic                   note_ok;
    logic                   same;
    logic [CHAN_W-1:0]      m_chan;
    logic [VEL_W-1:0]       m_vel;
    logic                   slot_free;
    logic                   wr_in_range;

    // entry codes of both tables, table select in the top address bit
    kmm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(RAM_DEPTH)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (code_waddr),
        .i_wdata (i_q.item.key),
        .i_raddr (code_raddr),
        .o_rdata (code_rd)
    );

    // note and channel that each entry currently sounds
    kmm_ram #(.WIDTH(HELD_W), .DEPTH(RAM_DEPTH)) u_held_ram (
        .i_clk   (i_clk),
        .i_we    (held_we),
        .i_waddr ({r_cmp_tbl, r_cmp_idx}),
        .i_wdata (held_wdata),
        .i_raddr ({r_cmp_tbl, r_cmp_idx}),
        .o_rdata (held_rd)
    );

    assign {held_note, held_chan} = held_rd;

    // counts above the table depth saturate
    assign lim_lo = (int'(i_cfg.lower_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(i_cfg.lower_count);
    assign lim_hi = (int'(i_cfg.upper_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(i_cfg.upper_count);
    assign lim    = (r_tbl == TBL_UPPER) ? lim_hi : lim_lo;

    assign code_raddr  = {r_tbl, r_ptr[TBL_AW-1:0]};
    assign hit         = r_cmp_vld && (code_rd == r_key);
    assign wr_in_range = (int'(i_q.item.idx) < TABLE_DEPTH);
    assign code_waddr  = {(i_q.item.cmd == CMD_WR_UPPER), TBL_AW'(i_q.item.idx)};

    assign o_pop   = (r_state == ST_IDLE) && i_q.valid;
    assign code_we = o_pop && i_q.item.is_write && wr_in_range;

    // note of the matched entry from its table's octave
    assign act     = (r_cmp_tbl == TBL_UPPER) ? r_act_hi[r_cmp_idx] : r_act_lo[r_cmp_idx];
    assign oct     = (r_cmp_tbl == TBL_UPPER) ? i_cfg.hi_oct : i_cfg.lo_oct;
    assign m_chan  = (r_cmp_tbl == TBL_UPPER) ? i_cfg.hi_chan : i_cfg.lo_chan;
    assign m_vel   = (r_cmp_tbl == TBL_UPPER) ? i_cfg.hi_vel : i_cfg.lo_vel;
    assign oct_p2  = signed'({oct[4], oct}) + OCT_BIAS;
    assign note_s  = 10'(oct_p2) * SEMITONES + signed'(10'(r_cmp_idx));
    assign note_ok = (note_s >= 10'sd0) && (note_s <= NOTE_MAX);
    assign same    = act && (signed'(10'(held_note)) == note_s);

    assign held_wdata = {note_s[NOTE_W-1:0], m_chan};
    assign held_we    = (r_state == ST_DECIDE) && !r_rel && !same && note_ok;

    assign slot_free = !r_out_vld || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_rel      = r_rel;
        n_key      = r_key;
        n_tbl      = r_tbl;
        n_ptr      = r_ptr;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_tbl  = r_cmp_tbl;
        n_cmp_idx  = r_cmp_idx;
        n_act_lo   = r_act_lo;
        n_act_hi   = r_act_hi;
        n_off_pend = r_off_pend;
        n_on_pend  = r_on_pend;
        n_off_note = r_off_note;
        n_off_chan = r_off_chan;
        n_on_note  = r_on_note;
        n_on_chan  = r_on_chan;
        n_on_vel   = r_on_vel;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_kind = r_out_kind;
        n_out_chan = r_out_chan;
        n_out_note = r_out_note;
        n_out_vel  = r_out_vel;
        n_out_last = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (i_q.item.is_write) begin
                        // writing an in-range entry clears its active mark
                        if (wr_in_range) begin
                            if (i_q.item.cmd == CMD_WR_UPPER) begin
                                n_act_hi[TBL_AW'(i_q.item.idx)] = 1'b0;
                            end else begin
                                n_act_lo[TBL_AW'(i_q.item.idx)] = 1'b0;
                            end
                        end
                    end else begin
                        n_rel     = (i_q.item.cmd == CMD_RELEASE);
                        n_key     = i_q.item.key;
                        n_tbl     = TBL_LOWER;
                        n_ptr     = '0;
                        n_cmp_vld = 1'b0;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // one entry issued per cycle, compared when its code comes back
                if (hit) begin
                    n_cmp_vld = 1'b0;
                    n_state   = ST_DECIDE;
                end else if (r_ptr < lim) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_tbl = r_tbl;
                    n_cmp_idx = r_ptr[TBL_AW-1:0];
                    n_ptr     = r_ptr + 1'b1;
                end else if (r_tbl == TBL_LOWER) begin
                    n_tbl     = TBL_UPPER;
                    n_ptr     = '0;
                    n_cmp_vld = 1'b0;
                end else begin
                    n_cmp_vld = 1'b0;
                    if (!r_cmp_vld) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DECIDE: begin
                n_off_note = held_note;
                n_off_chan = held_chan;
                n_on_note  = note_s[NOTE_W-1:0];
                n_on_chan  = m_chan;
                n_on_vel   = m_vel;
                if (r_rel) begin
                    n_off_pend = act;
                    n_on_pend  = 1'b0;
                    n_state    = act ? ST_EMIT : ST_IDLE;
                    if (r_cmp_tbl == TBL_UPPER) begin
                        n_act_hi[r_cmp_idx] = 1'b0;
                    end else begin
                        n_act_lo[r_cmp_idx] = 1'b0;
                    end
                end else if (same) begin
                    n_state = ST_IDLE;
                end else begin
                    n_off_pend = act;
                    n_on_pend  = note_ok;
                    n_state    = (act || note_ok) ? ST_EMIT : ST_IDLE;
                    if (r_cmp_tbl == TBL_UPPER) begin
                        n_act_hi[r_cmp_idx] = note_ok;
                    end else begin
                        n_act_lo[r_cmp_idx] = note_ok;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_vld = 1'b1;
                    if (r_off_pend) begin
                        n_out_kind = EV_OFF;
                        n_out_chan = r_off_chan;
                        n_out_note = r_off_note;
                        n_out_vel  = NOTE_OFF_VEL;
                        n_out_last = !r_on_pend;
                        n_off_pend = 1'b0;
                        if (!r_on_pend) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_out_kind = EV_ON;
                        n_out_chan = r_on_chan;
                        n_out_note = r_on_note;
                        n_out_vel  = r_on_vel;
                        n_out_last = 1'b1;
                        n_on_pend  = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cmp_vld  <= 1'b0;
            r_act_lo   <= '0;
            r_act_hi   <= '0;
            r_off_pend <= 1'b0;
            r_on_pend  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_vld  <= n_cmp_vld;
            r_act_lo   <= n_act_lo;
            r_act_hi   <= n_act_hi;
            r_off_pend <= n_off_pend;
            r_on_pend  <= n_on_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel      <= n_rel;
        r_key      <= n_key;
        r_tbl      <= n_tbl;
        r_ptr      <= n_ptr;
        r_cmp_tbl  <= n_cmp_tbl;
        r_cmp_idx  <= n_cmp_idx;
        r_off_note <= n_off_note;
        r_off_chan <= n_off_chan;
        r_on_note  <= n_on_note;
        r_on_chan  <= n_on_chan;
        r_on_vel   <= n_on_vel;
        r_out_kind <= n_out_kind;
        r_out_chan <= n_out_chan;
        r_out_note <= n_out_note;
        r_out_vel  <= n_out_vel;
        r_out_last <= n_out_last;
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.event_kind = r_out_kind;
    assign o_out.channel    = r_out_chan;
    assign o_out.note       = r_out_note;
    assign o_out.velocity   = r_out_vel;
    assign o_out.last       = r_out_last;

    assign o_stat.emitting  = (r_state == ST_EMIT);
    assign o_stat.searching = (r_state == ST_SCAN);
endmodule

// ===== design/key_to_midi_note_mapper.sv =====
// top level of the key to midi note mapper: configuration registers and the two halves
//
// Usage:
//   i_in carries key commands (press, release, write lower entry, write upper entry)
//   with valid/ready; an item is taken when both are high. A two-deep queue sits
//   behind i_in, so items are taken while earlier ones are still at work.
//   o_out carries midi note events, at most two per item (note-off, then note-on);
//   last marks the final event of an item. Items that cause nothing send nothing.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes one register
//   per cycle and is meant to be used while no item is in flight.
//   Flow: items run one at a time in the sequencer. A table write is stored when the
//   sequencer takes it from the queue. A press or release searches the lower table,
//   then the upper one, issuing one entry per cycle into the code memory's registered
//   read port; a match goes through a decision state and then loads its first event.
//   A second event follows once the output register is free, and the next item is
//   taken from the queue in the cycle after the last event is loaded.
//   Reset clears the queue, the sequencer, the output register and all active
//   marks, and loads the register defaults; key codes stay unknown until written.
//   When the receiver stalls, the event holds in the output register, the
//   sequencer waits behind it and the input queue fills, dropping i_in.ready.
module key_to_midi_note_mapper import kmm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kmm_in_if.sink                i_in,
    kmm_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    `include "key_to_midi_note_mapper_macros.svh"

    t_cfg       r_cfg;
    t_queue_out q;
    logic       back_pop;
    t_back_stat back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lo_oct      <= 5'd2;
            r_cfg.hi_oct      <= 5'd3;
            r_cfg.lo_vel      <= 7'd127;
            r_cfg.hi_vel      <= 7'd127;
            r_cfg.lo_chan     <= 4'd0;
            r_cfg.hi_chan     <= 4'd0;
            r_cfg.lower_count <= 6'd0;
            r_cfg.upper_count <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOWER_OCT:  r_cfg.lo_oct      <= i_cfg_data[4:0];
                CFG_UPPER_OCT:  r_cfg.hi_oct      <= i_cfg_data[4:0];
                CFG_LOWER_VEL:  r_cfg.lo_vel      <= i_cfg_data[6:0];
                CFG_UPPER_VEL:  r_cfg.hi_vel      <= i_cfg_data[6:0];
                CFG_LOWER_CHAN: r_cfg.lo_chan     <= i_cfg_data[3:0];
                CFG_UPPER_CHAN: r_cfg.hi_chan     <= i_cfg_data[3:0];
                CFG_LOWER_CNT:  r_cfg.lower_count <= i_cfg_data[5:0];
                CFG_UPPER_CNT:  r_cfg.upper_count <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    kmm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (back_pop),
        .o_q     (q)
    );

    kmm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q),
        .o_pop   (back_pop),
        .i_cfg   (r_cfg),
        .o_out   (o_out),
        .o_stat  (back_stat)
    );

    // a note-on always closes its item
    `KMM_ASSERT_NOW(a_on_is_last, o_out.valid && (o_out.event_kind == EV_ON), o_out.last,
        "note-on event not marked last")
    // note-offs go out at full velocity
    `KMM_ASSERT_NOW(a_off_vel, o_out.valid && (o_out.event_kind == EV_OFF),
        o_out.velocity == NOTE_OFF_VEL, "note-off event with wrong velocity")
    // while a non-final event waits, its note-on is still owed by the sequencer
    `KMM_ASSERT_NOW(a_pending_on, o_out.valid && !o_out.last, back_stat.emitting,
        "non-final event without a pending note-on")
    // no new item is taken from the queue during a table search
    `KMM_ASSERT_NOW(a_no_pop_in_search, back_stat.searching, !back_pop,
        "queue popped during a table search")
endmodule
